>>> src/fpop_pkg.sv
package fpop_pkg;

  localparam int CODE_W = 3;
  localparam int SIDE_W = 4;
  localparam int IDX_W  = 6;
  localparam int POS_W  = 3;

  localparam logic SHAPE_QUAD = 1'b0;
  localparam logic SHAPE_HEX  = 1'b1;

  typedef enum logic [CODE_W-1:0] {
    ORI_0 = 3'd0,
    ORI_1 = 3'd1,
    ORI_2 = 3'd2,
    ORI_3 = 3'd3,
    ORI_4 = 3'd4,
    ORI_5 = 3'd5,
    ORI_6 = 3'd6,
    ORI_7 = 3'd7
  } orient_t;

  // highest orientation a quadrilateral face accepts
  localparam orient_t QUAD_ORI_MAX = ORI_1;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic                quad;
    orient_t             code;
    logic [SIDE_W-1:0]   n;
  } job_t;

endpackage

>>> src/face_point_order_permutation.sv
// Face point reorder sequencer. Each accepted item (orient, side_points) yields
// the run of orientation-0 point indices for one face: N results for a
// quadrilateral face, N*N for a hexahedron face (N saturated to MAX_SIDE), the
// final one marked by last. An orientation the shape does not accept yields a
// single result with bad_orient and last set and point_index 0; a valid
// orientation with N = 0 yields nothing. One multiply-add unit computes one
// index per cycle while the sink takes every result and holds the scan while
// the output is stalled; in_ready is low until the last result has been
// loaded into the output register. The shape_kind register (reset 1, hexahedron)
// is written through cfg_valid.
module face_point_order_permutation #(
  parameter int MAX_SIDE = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            shape_kind,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fpop_pkg::CODE_W-1:0]     orient,
  input  logic [fpop_pkg::SIDE_W-1:0]     side_points,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fpop_pkg::IDX_W-1:0]      point_index,
  output logic                            last,
  output logic                            bad_orient
);
  import fpop_pkg::*;

  typedef enum logic [1:0] {IDLE, RUN, ERR} state_t;

  state_t              state;
  logic                kind;
  job_t                job;
  pos_t                a;
  pos_t                b;
  logic [SIDE_W-1:0]   n_sat;
  logic [SIDE_W-1:0]   nm1;
  logic                slot_free;
  logic                load;
  logic [IDX_W-1:0]    unit_idx;
  logic                unit_last;

  fpop_index_unit u_index (
    .job  (job),
    .a    (a),
    .b    (b),
    .idx  (unit_idx),
    .last (unit_last)
  );

  assign n_sat     = (side_points > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side_points;
  assign nm1       = job.n - SIDE_W'(1);
  assign slot_free = !out_valid || out_ready;
  assign load      = ((state == RUN) || (state == ERR)) && slot_free;
  assign in_ready  = (state == IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      kind      <= SHAPE_HEX;
    end else begin
      if (cfg_valid) begin
        kind <= shape_kind;
      end
      // raise valid on a new result, drop it once the item is taken
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            job.quad <= (kind == SHAPE_QUAD);
            job.code <= orient_t'(orient);
            job.n    <= n_sat;
            a        <= '0;
            b        <= '0;
            if (kind == SHAPE_QUAD && orient > QUAD_ORI_MAX) begin
              state <= ERR;
            end else if (n_sat != '0) begin
              state <= RUN;
            end
          end
        end
        RUN: begin
          // emit one index and advance the scan
          if (slot_free) begin
            point_index <= unit_idx;
            last        <= unit_last;
            bad_orient  <= 1'b0;
            if (unit_last) begin
              state <= IDLE;
            end else if (b == nm1[POS_W-1:0]) begin
              b <= '0;
              a <= a + pos_t'(1);
            end else begin
              b <= b + pos_t'(1);
            end
          end
        end
        ERR: begin
          if (slot_free) begin
            point_index <= '0;
            last        <= 1'b1;
            bad_orient  <= 1'b1;
            state       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> src/fpop_index_unit.sv
module fpop_index_unit (
  input  fpop_pkg::job_t                 job,
  input  fpop_pkg::pos_t                 a,
  input  fpop_pkg::pos_t                 b,
  output logic [fpop_pkg::IDX_W-1:0]     idx,
  output logic                           last
);
  import fpop_pkg::*;

  logic [SIDE_W-1:0]     nm1;
  pos_t                  side_m1;
  pos_t                  ra;
  pos_t                  rb;
  pos_t                  row;
  pos_t                  col;
  pos_t                  rows_m1;
  logic [IDX_W:0]        prod;
  logic [IDX_W:0]        sum;

  // mirrored coordinates
  assign nm1     = job.n - SIDE_W'(1);
  assign side_m1 = nm1[POS_W-1:0];
  assign ra      = side_m1 - a;
  assign rb      = side_m1 - b;

  // pick row and column of the source point for this orientation
  always_comb begin
    row = '0;
    col = b;
    if (job.quad) begin
      row = '0;
      col = (job.code == ORI_0) ? b : rb;
    end else begin
      unique case (job.code)
        ORI_0: begin row = a;  col = b;  end
        ORI_1: begin row = b;  col = ra; end
        ORI_2: begin row = ra; col = rb; end
        ORI_3: begin row = rb; col = a;  end
        ORI_4: begin row = b;  col = a;  end
        ORI_5: begin row = a;  col = rb; end
        ORI_6: begin row = rb; col = ra; end
        ORI_7: begin row = ra; col = b;  end
        default: begin row = a; col = b; end
      endcase
    end
  end

  // shared multiply-add: row * N + col
  assign prod = (IDX_W+1)'(row) * (IDX_W+1)'(job.n);
  assign sum  = prod + (IDX_W+1)'(col);
  assign idx  = sum[IDX_W-1:0];

  // flag the final position of the scan
  assign rows_m1 = job.quad ? pos_t'(0) : side_m1;
  assign last    = (a == rows_m1) && (b == side_m1);

endmodule

>>> src/fpop_checker.sv
module fpop_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [fpop_pkg::IDX_W-1:0]      point_index,
  input logic                            last,
  input logic                            bad_orient
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_index) && $stable(last)
      && $stable(bad_orient))
    else $error("stalled result changed");

  // error result stands alone with index zero
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_orient |-> last && (point_index == '0))
    else $error("error result malformed");

  // no new item while a run is unfinished
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input ready in the middle of a run");

endmodule

bind face_point_order_permutation fpop_checker u_fpop_checker (.*);
